[sv/pointer_event_tracker_core_macros.svh]
// assertion helpers for the tracker modules, used by pet_back
// both expect clk and arst_n in the scope of the use
`ifndef POINTER_EVENT_TRACKER_CORE_MACROS_SVH
`define POINTER_EVENT_TRACKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define PET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PET_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PET_ASSERT(lbl, prop, msg)
`define PET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[sv/pet_pkg.sv]
package pet_pkg;

	localparam int NUM_MSG = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [3:0] {
		MSG_MOVE  = 4'd0,
		MSG_LDOWN = 4'd1,
		MSG_LUP   = 4'd2,
		MSG_RDOWN = 4'd3,
		MSG_RUP   = 4'd4,
		MSG_MDOWN = 4'd5,
		MSG_MUP   = 4'd6,
		MSG_WHEEL = 4'd7,
		MSG_XDOWN = 4'd8,
		MSG_XUP   = 4'd9
	} msg_code_t;

	// event flag bit positions
	localparam int FLG_MOVE  = 0;
	localparam int FLG_LDOWN = 1;
	localparam int FLG_LUP   = 2;
	localparam int FLG_RDOWN = 3;
	localparam int FLG_RUP   = 4;
	localparam int FLG_MDOWN = 5;
	localparam int FLG_MUP   = 6;
	localparam int FLG_XDOWN = 7;
	localparam int FLG_XUP   = 8;
	localparam int FLG_WHEEL = 11;
	localparam int FLG_ABS   = 15;

	// button state bit positions
	localparam int BTN_L  = 0;
	localparam int BTN_R  = 1;
	localparam int BTN_M  = 2;
	localparam int BTN_X1 = 3;
	localparam int BTN_X2 = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SWAP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_LO   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR_HI   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_W = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_H = 3'd5;

	localparam logic [15:0] RST_THR_LO   = 16'd6;
	localparam logic [15:0] RST_THR_HI   = 16'd10;
	localparam logic [1:0]  RST_LEVEL    = 2'd1;
	localparam logic [15:0] RST_SCREEN_W = 16'd1024;
	localparam logic [15:0] RST_SCREEN_H = 16'd768;

	localparam logic [1:0] LEVEL_OFF = 2'd0;
	localparam logic [1:0] LEVEL_QUAD = 2'd2;

	typedef logic [NUM_MSG-1:0] msg_vec_t;

	typedef struct packed {
		logic [15:0] thr_lo;
		logic [15:0] thr_hi;
		logic [1:0]  level;
		logic [15:0] scr_w;
		logic [15:0] scr_h;
	} front_cfg_t;

	// fields of one event that the back end needs besides the position
	typedef struct packed {
		logic [31:0] window;
		logic [15:0] data;
		logic [31:0] stamp;
		logic [31:0] extra;
		logic        injected;
		msg_vec_t    msgs;
	} evt_info_t;

endpackage

[sv/pet_queue.sv]
module pet_queue
	import pet_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

[sv/pet_front.sv]
module pet_front
	import pet_pkg::*;
#(
	parameter int COORD_BITS = 17,
	parameter int IN_W = 152,
	parameter int QW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [IN_W-1:0] s_tdata,
	input  logic [16:0]     s_tuser,
	input  front_cfg_t      cfg,
	input  logic            q_full,
	output logic            q_push,
	output logic [QW-1:0]   q_wdata
);

	localparam int C  = COORD_BITS;
	localparam int MW = (C > 16) ? C : 16;
	localparam int VW = (C + 3 > 18) ? C + 3 : 18;
	localparam int PW = C + 17;
	localparam logic signed [VW-1:0] CMAX = VW'((64'(1) << (C - 1)) - 64'(1));

	// stage 1: raw item
	logic              v_s1;
	logic [31:0]       win_s1, time_s1, extra_s1;
	logic [15:0]       flags_s1, data_s1;
	logic signed [C-1:0] cx_s1, cy_s1;
	logic              inj_s1;

	// stage 2: scaled and accelerated coordinates
	logic              v_s2, abs_s2, move_s2;
	logic signed [C-1:0]   absx_s2, absy_s2;
	logic signed [C+1:0]   accx_s2, accy_s2;
	evt_info_t         info_s2;

	logic [15:0] w_eff, h_eff;
	logic signed [C-1:0] cur_x_q, cur_y_q;
	logic signed [PW-1:0] prod_x, prod_y;
	logic signed [C-1:0] new_x, new_y;
	logic adv_s1, adv_s2;
	msg_vec_t msgs_s1;

	assign w_eff = (cfg.scr_w == '0) ? 16'd1 : cfg.scr_w;
	assign h_eff = (cfg.scr_h == '0) ? 16'd1 : cfg.scr_h;

	function automatic logic signed [C+1:0] accel(
		input logic signed [C-1:0] d,
		input logic [15:0] lo,
		input logic [15:0] hi,
		input logic [1:0] level
	);
		logic [C-1:0] mag;
		logic dbl, quad;
		logic signed [C+1:0] dext;
		mag  = d[C-1] ? ($unsigned(~d) + C'(1)) : $unsigned(d);
		dbl  = (MW'(mag) > MW'(lo)) && (level != LEVEL_OFF);
		quad = dbl && (MW'(mag) > MW'(hi)) && (level == LEVEL_QUAD);
		dext = (C+2)'(d);
		if (quad) begin
			return dext <<< 2;
		end else if (dbl) begin
			return dext <<< 1;
		end
		return dext;
	endfunction

	function automatic logic signed [C-1:0] clip(
		input logic signed [C-1:0] cur,
		input logic signed [C+1:0] acc,
		input logic [15:0] size
	);
		logic signed [VW-1:0] sum, lim;
		sum = VW'(cur) + VW'(acc);
		lim = VW'({1'b0, size - 16'd1});
		if (lim > CMAX) begin
			lim = CMAX;
		end
		if (sum < 0) begin
			return '0;
		end else if (sum > lim) begin
			return lim[C-1:0];
		end
		return sum[C-1:0];
	endfunction

	assign adv_s2 = v_s2 && (!q_full || (info_s2.msgs == '0));
	assign adv_s1 = v_s1 && (!v_s2 || adv_s2);
	assign s_tready = !v_s1 || adv_s1;

	assign prod_x = PW'(cx_s1) * $signed({{(PW-17){1'b0}}, 1'b0, w_eff});
	assign prod_y = PW'(cy_s1) * $signed({{(PW-17){1'b0}}, 1'b0, h_eff});

	// messages in code order
	assign msgs_s1 = {flags_s1[FLG_XUP], flags_s1[FLG_XDOWN], flags_s1[FLG_WHEEL],
		flags_s1[FLG_MUP], flags_s1[FLG_MDOWN], flags_s1[FLG_RUP], flags_s1[FLG_RDOWN],
		flags_s1[FLG_LUP], flags_s1[FLG_LDOWN], flags_s1[FLG_MOVE]};

	always_comb begin
		new_x = cur_x_q;
		new_y = cur_y_q;
		if (abs_s2) begin
			new_x = absx_s2;
			new_y = absy_s2;
		end else if (move_s2) begin
			new_x = clip(cur_x_q, accx_s2, w_eff);
			new_y = clip(cur_y_q, accy_s2, h_eff);
		end
	end

	assign q_push  = v_s2 && !q_full && (info_s2.msgs != '0);
	assign q_wdata = {new_y, new_x, info_s2};

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			win_s1   <= s_tdata[31:0];
			cx_s1    <= s_tdata[32 +: C];
			cy_s1    <= s_tdata[32 + C +: C];
			data_s1  <= s_tdata[32 + 2*C +: 16];
			time_s1  <= s_tdata[48 + 2*C +: 32];
			extra_s1 <= s_tdata[80 + 2*C +: 32];
			flags_s1 <= s_tuser[15:0];
			inj_s1   <= s_tuser[16];
		end
		if (adv_s1) begin
			abs_s2  <= flags_s1[FLG_ABS];
			move_s2 <= flags_s1[FLG_MOVE];
			// floor of coord * size / 65536 is an arithmetic shift of the product
			absx_s2 <= inj_s1 ? prod_x[C+15:16] : cx_s1;
			absy_s2 <= inj_s1 ? prod_y[C+15:16] : cy_s1;
			accx_s2 <= accel(cx_s1, cfg.thr_lo, cfg.thr_hi, cfg.level);
			accy_s2 <= accel(cy_s1, cfg.thr_lo, cfg.thr_hi, cfg.level);
			info_s2.window   <= win_s1;
			info_s2.data     <= data_s1;
			info_s2.stamp    <= time_s1;
			info_s2.extra    <= extra_s1;
			info_s2.injected <= inj_s1;
			info_s2.msgs     <= msgs_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (adv_s2) begin
				v_s2 <= 1'b0;
			end
			if (adv_s2) begin
				cur_x_q <= new_x;
				cur_y_q <= new_y;
			end
		end
	end

endmodule

[sv/pet_back.sv]
`include "pointer_event_tracker_core_macros.svh"

module pet_back
	import pet_pkg::*;
#(
	parameter int COORD_BITS = 17,
	parameter int OUT_W = 160,
	parameter int QW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             swap,
	input  logic             q_empty,
	output logic             q_pop,
	input  logic [QW-1:0]    q_rdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	output logic [4:0]       m_tuser,
	output logic             m_tlast
);

	localparam int C = COORD_BITS;

	evt_info_t       rec_in, rec_q;
	logic [C-1:0]    px_in, py_in, px_q, py_q;
	logic            busy_q;
	msg_vec_t        pend_q, pend_next;
	logic [4:0]      down_q, latched_q, down_next, latched_next, xb;
	msg_code_t       idx, code;
	logic            slot_free, emit, last;
	logic [6:0]      mask;
	logic            bl, br;

	// output register
	logic            ovalid_q;
	msg_code_t       code_q;
	logic [31:0]     win_q, time_q, extra_q;
	logic [C-1:0]    opx_q, opy_q;
	logic [6:0]      mask_q;
	logic [15:0]     data_q;
	logic            inj_q, last_q;

	assign {py_in, px_in, rec_in} = q_rdata;

	assign slot_free = !ovalid_q || m_tready;
	assign emit = busy_q && slot_free;

	always_comb begin
		idx = MSG_MOVE;
		for (int k = NUM_MSG - 1; k >= 0; k--) begin
			if (pend_q[k]) begin
				idx = msg_code_t'(4'(k));
			end
		end
	end

	assign pend_next = pend_q & ~(msg_vec_t'(1) << idx);
	assign last = (pend_next == '0);
	assign q_pop = !q_empty && (!busy_q || (emit && last));

	always_comb begin
		unique case (rec_q.data)
			16'd1:   xb = 5'(1) << BTN_X1;
			16'd2:   xb = 5'(1) << BTN_X2;
			default: xb = '0;
		endcase
	end

	always_comb begin
		down_next = down_q;
		latched_next = latched_q;
		code = idx;
		unique case (idx)
			MSG_LDOWN: begin
				down_next[BTN_L] = 1'b1;
				latched_next[BTN_L] = 1'b1;
				code = swap ? MSG_RDOWN : MSG_LDOWN;
			end
			MSG_LUP: begin
				down_next[BTN_L] = 1'b0;
				code = swap ? MSG_RUP : MSG_LUP;
			end
			MSG_RDOWN: begin
				down_next[BTN_R] = 1'b1;
				latched_next[BTN_R] = 1'b1;
				code = swap ? MSG_LDOWN : MSG_RDOWN;
			end
			MSG_RUP: begin
				down_next[BTN_R] = 1'b0;
				code = swap ? MSG_LUP : MSG_RUP;
			end
			MSG_MDOWN: begin
				down_next[BTN_M] = 1'b1;
				latched_next[BTN_M] = 1'b1;
			end
			MSG_MUP: begin
				down_next[BTN_M] = 1'b0;
			end
			MSG_XDOWN: begin
				down_next = down_q | xb;
				latched_next = latched_q | xb;
			end
			MSG_XUP: begin
				down_next = down_q & ~xb;
			end
			default: begin
			end
		endcase
	end

	// swap exchanges left and right in the reported mask and in the message codes
	assign bl = swap ? down_next[BTN_R] : down_next[BTN_L];
	assign br = swap ? down_next[BTN_L] : down_next[BTN_R];
	assign mask = {down_next[BTN_X2], down_next[BTN_X1], down_next[BTN_M], 2'b00, br, bl};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rec_q <= rec_in;
			px_q  <= px_in;
			py_q  <= py_in;
		end
		if (emit) begin
			code_q  <= code;
			win_q   <= rec_q.window;
			opx_q   <= px_q;
			opy_q   <= py_q;
			mask_q  <= mask;
			data_q  <= rec_q.data;
			time_q  <= rec_q.stamp;
			extra_q <= rec_q.extra;
			inj_q   <= rec_q.injected;
			last_q  <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			pend_q    <= '0;
			down_q    <= '0;
			latched_q <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				pend_q <= rec_in.msgs;
			end else if (emit) begin
				busy_q <= !last;
				pend_q <= pend_next;
			end
			if (emit) begin
				down_q    <= down_next;
				latched_q <= latched_next;
				ovalid_q  <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = OUT_W'({extra_q, time_q, data_q, mask_q, opy_q, opx_q, win_q});
	assign m_tuser  = {inj_q, code_q};
	assign m_tlast  = last_q;

	`PET_ASSERT(a_latched_covers_down, (down_q & ~latched_q) == 5'd0, "button down but not latched")
	`PET_ASSERT(a_busy_has_pending, busy_q |-> (pend_q != '0), "busy with no message pending")
	`PET_ASSERT(a_pop_not_empty, q_pop |-> !q_empty, "pop from empty queue")
	`PET_ASSERT_NEXT(a_last_retires, emit && last && !q_pop, !busy_q, "event not retired")

endmodule

[sv/pointer_event_tracker_core.sv]
// pointer event tracker
// s_* takes one pointer event per item: s_tdata carries window, x, y, data,
// time and extra word, s_tuser the event flags and the injected mark.
// m_* gives the messages of an event, one per cycle while m_tready is high, in
// code order, each with the cursor position after the event and the button
// mask after that message; m_tlast marks the last message of the event. events
// without message flags only move the cursor and give no item.
// cfg_we writes cfg_wdata to register cfg_index in the same edge.
// the front end takes one event per cycle while the queue has room, through two
// stages (scale multiply and accelerate, then add and clip against the cursor
// register) into a four-entry queue; the back end walks the message flags of
// one event, one message a cycle while m_tready is high, into an output
// register. an event holds the back end until its last message is emitted.
// when m_tready is low the output register holds, the queue fills and
// s_tready drops once both front stages are full.
// reset puts the cursor at 0,0, releases all buttons and loads the register
// defaults.
module pointer_event_tracker_core
	import pet_pkg::*;
#(
	parameter int COORD_BITS = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// window_handle, coord_x, coord_y, event_data, event_time, extra_word
	input  logic [((112 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// event_flags, injected
	input  logic [16:0]           s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// out_window, pos_x, pos_y, button_mask, out_data, out_time, out_extra
	output logic [((119 + 2*COORD_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	// message_code, out_injected
	output logic [4:0]            m_tuser,
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int IN_W  = ((112 + 2*COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((119 + 2*COORD_BITS + 7) / 8) * 8;
	localparam int QW    = $bits(evt_info_t) + 2*COORD_BITS;

	front_cfg_t      cfg_q;
	logic            swap_q;
	logic            q_push, q_pop, q_full, q_empty;
	logic [QW-1:0]   q_wdata, q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q       <= 1'b0;
			cfg_q.thr_lo <= RST_THR_LO;
			cfg_q.thr_hi <= RST_THR_HI;
			cfg_q.level  <= RST_LEVEL;
			cfg_q.scr_w  <= RST_SCREEN_W;
			cfg_q.scr_h  <= RST_SCREEN_H;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SWAP:     swap_q       <= cfg_wdata[0];
				CFG_THR_LO:   cfg_q.thr_lo <= cfg_wdata;
				CFG_THR_HI:   cfg_q.thr_hi <= cfg_wdata;
				CFG_LEVEL:    cfg_q.level  <= cfg_wdata[1:0];
				CFG_SCREEN_W: cfg_q.scr_w  <= cfg_wdata;
				CFG_SCREEN_H: cfg_q.scr_h  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pet_front #(
		.COORD_BITS(COORD_BITS),
		.IN_W(IN_W),
		.QW(QW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.cfg(cfg_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	pet_queue #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.rdata(q_rdata),
		.full(q_full),
		.empty(q_empty)
	);

	pet_back #(
		.COORD_BITS(COORD_BITS),
		.OUT_W(OUT_W),
		.QW(QW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.swap(swap_q),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_rdata(q_rdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
